[design/xcd_pkg.sv]
package xcd_pkg;

  // Result kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOF_CODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CUTOFF = 1'b1;
  localparam int unsigned CFG_DATA_W = 9;

  // Register reset values
  localparam logic [7:0] SOF_CODE_RST    = 8'h00;
  localparam logic [8:0] TYPE_CUTOFF_RST = 9'h100;

  // Depth of the queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned OUT_DATA_W = 32;

  // One result record
  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic [7:0] frame_length;
    logic [7:0] frame_type;
  } result_t;

endpackage

[design/xor_checksum_packet_deframer.sv]
// Path: a taken byte's result is written into the result queue and from there into the output
// register, which presents it on m_axis.
// Throughput: one byte per cycle while s_axis_tready is high; the parser updates its frame state per byte.
// Stalls: s_axis_tready drops only while the result queue is full, i.e. with three results
// waiting behind a stalled m_axis; bytes with no result then wait as well.
// Reset (rst_ni low, asynchronous): parser hunts the frame opener, counters clear, the
// opener code returns to 0, type_cutoff to 256, queue and output register empty.
module xor_checksum_packet_deframer #(
  parameter int unsigned QueueDepth = xcd_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [xcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [xcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] frame_type, [15:8] frame_length, [23:16] payload_byte, [31:24] payload_index
  output logic [xcd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]                     m_axis_tuser   // [1:0] result_kind
);
  import xcd_pkg::*;

  logic    space, push, avail, pop;
  result_t push_data, pop_data;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = space;

  xcd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .space_i      (space),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  xcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (space),
    .pop_i       (pop),
    .avail_o     (avail),
    .pop_data_o  (pop_data)
  );

  xcd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (avail),
    .data_i        (pop_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[design/xcd_parser.sv]
module xcd_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [xcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [xcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           byte_valid_i,
  input  logic [7:0]                     byte_i,
  input  logic                           space_i,
  output logic                           push_o,
  output xcd_pkg::result_t               push_data_o
);
  import xcd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] check_q, check_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] type_q, type_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sof_code_q;
  logic [8:0] type_cutoff_q;
  logic       take;
  logic [7:0] seen_inc;

  assign take     = byte_valid_i & space_i;
  assign seen_inc = seen_q + 8'd1;

  // Next state and result classification
  always_comb begin
    phase_d     = phase_q;
    check_d     = check_q;
    seen_d      = seen_q;
    type_d      = type_q;
    len_d       = len_q;
    push_o      = 1'b0;
    push_data_o = '{kind: KIND_PAYLOAD, payload_index: 8'd0, payload_byte: 8'd0,
                    frame_length: len_q, frame_type: type_q};
    unique case (phase_q)
      PH_TYPE: begin
        type_d = byte_i;
        if ({1'b0, byte_i} >= type_cutoff_q) begin
          phase_d = PH_IDLE;
        end else begin
          check_d = check_q ^ byte_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        len_d   = byte_i;
        check_d = check_q ^ byte_i;
        phase_d = (byte_i != 8'd0) ? PH_DATA : PH_CHECK;
      end
      PH_DATA: begin
        push_o                    = take;
        push_data_o.payload_byte  = byte_i;
        push_data_o.payload_index = seen_q;
        seen_d                    = seen_inc;
        check_d                   = check_q ^ byte_i;
        if (seen_inc == len_q) phase_d = PH_CHECK;
      end
      PH_CHECK: begin
        push_o           = take;
        push_data_o.kind = (check_q == byte_i) ? KIND_GOOD : KIND_BAD;
        phase_d          = PH_IDLE;
      end
      default: begin
        if (byte_i == sof_code_q) begin
          check_d = sof_code_q;
          seen_d  = 8'd0;
          phase_d = PH_TYPE;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  // Parse state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      check_q       <= 8'd0;
      seen_q        <= 8'd0;
      type_q        <= 8'd0;
      len_q         <= 8'd0;
      sof_code_q    <= SOF_CODE_RST;
      type_cutoff_q <= TYPE_CUTOFF_RST;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        check_q <= check_d;
        seen_q  <= seen_d;
        type_q  <= type_d;
        len_q   <= len_d;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SOF_CODE:    sof_code_q    <= cfg_data_i[7:0];
          CFG_TYPE_CUTOFF: type_cutoff_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[design/xcd_queue.sv]
module xcd_queue #(
  parameter int unsigned Depth = xcd_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xcd_pkg::result_t push_data_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             avail_o,
  output xcd_pkg::result_t pop_data_o
);
  import xcd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  result_t         entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign space_o    = (count_q != FullCnt);
  assign avail_o    = (count_q != '0);
  assign do_push    = push_i & space_o;
  assign do_pop     = pop_i & avail_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

endmodule

[design/xcd_out_stage.sv]
module xcd_out_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               avail_i,
  input  xcd_pkg::result_t                   data_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [xcd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                         m_axis_tuser
);
  import xcd_pkg::*;

  logic    valid_q;
  result_t data_q;

  // Refill whenever the register is empty or being drained
  assign pop_o = avail_i & (~valid_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || m_axis_tready) begin
      valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= data_i;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = data_q.kind;
  assign m_axis_tdata  = {data_q.payload_index, data_q.payload_byte,
                          data_q.frame_length, data_q.frame_type};

endmodule

[design/xcd_checker.sv]
module xcd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [xcd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser
);
  import xcd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only defined kinds leave the block
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_PAYLOAD) || (m_axis_tuser == KIND_GOOD)
      || (m_axis_tuser == KIND_BAD))
    else $error("undefined result kind");

  // End-of-frame results carry zero payload byte and index
  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_PAYLOAD) |-> m_axis_tdata[31:16] == 16'd0)
    else $error("verdict carries payload fields");

  // Payload index stays below the declared length
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD)
      |-> m_axis_tdata[31:24] < m_axis_tdata[15:8])
    else $error("payload index beyond frame length");

  // Input stalls only while a result waits at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output idle");

endmodule

bind xor_checksum_packet_deframer xcd_checker u_xcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
